// File: rtl/ltc_pkg.sv
// ltc_pkg: shared types, codes and default sizes for the lagged transition counter.
// Used by every module under rtl/ except ltc_fifo; depends on nothing.
package ltc_pkg;

  // Defaults for the top-level parameters
  localparam int N_STATES_DEF   = 64;
  localparam int MAX_LAG_DEF    = 64;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths of the ports
  localparam int LAG_W   = 7;
  localparam int ID_W    = 8;
  localparam int RD_ID_W = 6;
  localparam int OUT_W   = 32;
  // Width wide enough to compare any id against a state count of up to 256
  localparam int IDC_W   = 9;

  // Depths of the command queue and the result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  // What the back end does with one queued command
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_COUNT = 2'd2
  } op_t;

  typedef struct packed {
    op_t  op;
    logic bad;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] count_value;
    logic             pair_counted;
    logic             id_out_of_range;
  } result_t;

endpackage

// File: rtl/lagged_transition_counter.sv
// lagged_transition_counter: top level; front end, command queue, count store back end
// and result queue. Uses ltc_pkg, ltc_front, ltc_fifo and ltc_back.
//
// Usage:
//   Items enter through push/full: in_func 0 pushes a trajectory sample (in_state_id,
//   in_segment_start), in_func 1 reads the count of pair (in_read_from, in_read_to).
//   Every item gives exactly one result on the empty/pop side, in order.
//   The lag register is written through cfg_valid/cfg_ready/cfg_lag_steps, always ready;
//   write it only while no transaction is in flight.
//   Path: front-stage register, command queue, back-end stage register, result queue.
//   Throughput: one item per cycle while full is low; back-to-back updates of the same
//   pair in the count store are forwarded.
//   Reset: the count store is cleared one entry per cycle over all N_STATES*N_STATES
//   entries (4096 at the defaults); full stays high until that pass ends.
//   Stalls: results wait in a four-deep result queue; once it and the four-deep command
//   queue fill up, full rises and the input waits.
module lagged_transition_counter #(
  parameter int N_STATES   = ltc_pkg::N_STATES_DEF,
  parameter int MAX_LAG    = ltc_pkg::MAX_LAG_DEF,
  parameter int COUNT_BITS = ltc_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_func,
  input  logic [ltc_pkg::ID_W-1:0]      in_state_id,
  input  logic                          in_segment_start,
  input  logic [ltc_pkg::RD_ID_W-1:0]   in_read_from,
  input  logic [ltc_pkg::RD_ID_W-1:0]   in_read_to,
  output logic                          empty,
  input  logic                          pop,
  output logic [ltc_pkg::OUT_W-1:0]     out_count_value,
  output logic                          out_pair_counted,
  output logic                          out_id_out_of_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ltc_pkg::LAG_W-1:0]     cfg_lag_steps
);

  localparam int AW  = $clog2(N_STATES * N_STATES);
  localparam int QW  = $bits(ltc_pkg::cmd_t) + AW;
  localparam int RW  = $bits(ltc_pkg::result_t);
  localparam int QCW = $clog2(ltc_pkg::QUEUE_DEPTH + 1);
  localparam int OCW = $clog2(ltc_pkg::OUT_DEPTH + 1);

  logic             clr_busy;
  logic             q_push;
  ltc_pkg::cmd_t    q_cmd;
  logic [AW-1:0]    q_idx;
  logic [QCW-1:0]   q_count;
  logic             q_empty;
  logic             q_pop;
  logic [QW-1:0]    q_rdata;
  ltc_pkg::cmd_t    q_head_cmd;
  logic [AW-1:0]    q_head_idx;
  logic             o_push;
  ltc_pkg::result_t o_data;
  logic [OCW-1:0]   o_count;
  logic [RW-1:0]    o_rdata;
  ltc_pkg::result_t o_head;

  assign cfg_ready = 1'b1;

  ltc_front #(
    .N_STATES (N_STATES),
    .MAX_LAG  (MAX_LAG)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_state_id      (in_state_id),
    .in_segment_start (in_segment_start),
    .in_read_from     (in_read_from),
    .in_read_to       (in_read_to),
    .cfg_valid        (cfg_valid),
    .cfg_lag_steps    (cfg_lag_steps),
    .clr_busy         (clr_busy),
    .q_count          (q_count),
    .q_push           (q_push),
    .q_cmd            (q_cmd),
    .q_idx            (q_idx)
  );

  ltc_fifo #(
    .W (QW),
    .D (ltc_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({q_cmd, q_idx}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  assign {q_head_cmd, q_head_idx} = q_rdata;

  ltc_back #(
    .N_STATES   (N_STATES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_head_cmd),
    .q_idx    (q_head_idx),
    .q_pop    (q_pop),
    .o_count  (o_count),
    .o_push   (o_push),
    .o_data   (o_data),
    .clr_busy (clr_busy)
  );

  ltc_fifo #(
    .W (RW),
    .D (ltc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_data),
    .pop   (pop && !empty),
    .rdata (o_rdata),
    .empty (empty),
    .count (o_count)
  );

  assign o_head              = o_rdata;
  assign out_count_value     = o_head.count_value;
  assign out_pair_counted    = o_head.pair_counted;
  assign out_id_out_of_range = o_head.id_out_of_range;

endmodule

// File: rtl/ltc_fifo.sv
// ltc_fifo: small register-based first-in first-out queue with an occupancy count.
// Depends on nothing; depth and width come from the instantiating module.
module ltc_fifo #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [W-1:0]           wdata,
  input  logic                   pop,
  output logic [W-1:0]           rdata,
  output logic                   empty,
  output logic [$clog2(D+1)-1:0] count
);

  localparam int PTW = (D > 1) ? $clog2(D) : 1;
  localparam int CNW = $clog2(D + 1);

  logic [W-1:0]   store_r [D];
  logic [PTW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTW'(D - 1)) ? '0 : wr_ptr_r + PTW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTW'(D - 1)) ? '0 : rd_ptr_r + PTW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = store_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

// File: rtl/ltc_front.sv
// ltc_front: accepts items, keeps the lag register, the sample history and the segment
// position, and classifies each item into a command for the back end. Uses ltc_pkg.
module ltc_front #(
  parameter int N_STATES = ltc_pkg::N_STATES_DEF,
  parameter int MAX_LAG  = ltc_pkg::MAX_LAG_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         push,
  output logic                                         full,
  input  logic                                         in_func,
  input  logic [ltc_pkg::ID_W-1:0]                     in_state_id,
  input  logic                                         in_segment_start,
  input  logic [ltc_pkg::RD_ID_W-1:0]                  in_read_from,
  input  logic [ltc_pkg::RD_ID_W-1:0]                  in_read_to,
  input  logic                                         cfg_valid,
  input  logic [ltc_pkg::LAG_W-1:0]                    cfg_lag_steps,
  input  logic                                         clr_busy,
  input  logic [$clog2(ltc_pkg::QUEUE_DEPTH+1)-1:0]    q_count,
  output logic                                         q_push,
  output ltc_pkg::cmd_t                                q_cmd,
  output logic [$clog2(N_STATES*N_STATES)-1:0]         q_idx
);

  localparam int SW  = $clog2(N_STATES);
  localparam int AW  = $clog2(N_STATES * N_STATES);
  localparam int HW  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int PW  = $clog2(MAX_LAG + 1);
  localparam int CW  = ((PW > ltc_pkg::LAG_W) ? PW : ltc_pkg::LAG_W) + 1;
  localparam int QCW = $clog2(ltc_pkg::QUEUE_DEPTH + 1);
  localparam int QSW = QCW + 1;
  localparam int IW  = ltc_pkg::IDC_W;

  logic [ltc_pkg::LAG_W-1:0] lag_r;
  logic [HW-1:0]             wp_r, wp_nxt;
  logic [PW-1:0]             pos_r, pos_nxt;
  logic [ltc_pkg::ID_W-1:0]  hist_r [MAX_LAG];
  logic [ltc_pkg::ID_W-1:0]  hist_rd_r;

  logic          s1_valid_r;
  logic          s1_read_r;
  logic          s1_bad_r;
  logic          s1_elig_r;
  logic [SW-1:0] s1_cur_r;
  logic [SW-1:0] s1_from_r;
  logic [SW-1:0] s1_to_r;

  logic          accept;
  logic [CW-1:0] lag_ext;
  logic [CW-1:0] eff_lag;
  logic [CW-1:0] slot_sum;
  logic [HW-1:0] slot;
  logic [PW-1:0] pos_eff;
  logic          elig;
  logic          cur_bad;
  logic          rd_bad;
  logic          prev_ok;
  logic [SW-1:0] row;
  logic [SW-1:0] col;

  // Hold new items back while the store is cleared or the queue has no guaranteed slot
  assign full   = clr_busy
                  || ((QSW'(q_count) + QSW'(s1_valid_r)) >= QSW'(ltc_pkg::QUEUE_DEPTH));
  assign accept = push && !full;

  always_comb begin
    lag_ext = CW'(lag_r);
    if (lag_ext == '0) begin
      eff_lag = CW'(1);
    end else if (lag_ext > CW'(MAX_LAG)) begin
      eff_lag = CW'(MAX_LAG);
    end else begin
      eff_lag = lag_ext;
    end
    slot_sum = CW'(wp_r) + CW'(MAX_LAG) - eff_lag;
    slot     = (slot_sum >= CW'(MAX_LAG)) ? HW'(slot_sum - CW'(MAX_LAG)) : HW'(slot_sum);
    // A segment start restarts the position before the pair test
    pos_eff  = in_segment_start ? '0 : pos_r;
    elig     = CW'(pos_eff) >= eff_lag;
    cur_bad  = IW'(in_state_id) >= IW'(N_STATES);
    rd_bad   = (IW'(in_read_from) >= IW'(N_STATES)) || (IW'(in_read_to) >= IW'(N_STATES));
    wp_nxt   = (wp_r == HW'(MAX_LAG - 1)) ? '0 : wp_r + HW'(1);
    pos_nxt  = (pos_eff == PW'(MAX_LAG)) ? pos_eff : pos_eff + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r      <= ltc_pkg::LAG_W'(1);
      wp_r       <= '0;
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (cfg_valid) begin
        lag_r <= cfg_lag_steps;
      end
      if (accept && !in_func) begin
        wp_r  <= wp_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read_r <= in_func;
      s1_bad_r  <= in_func ? rd_bad : cur_bad;
      s1_elig_r <= elig;
      s1_cur_r  <= SW'(IW'(in_state_id));
      s1_from_r <= SW'(IW'(in_read_from));
      s1_to_r   <= SW'(IW'(in_read_to));
      hist_rd_r <= hist_r[slot];
      if (!in_func) begin
        hist_r[wp_r] <= in_state_id;
      end
    end
  end

  // Second front stage: pair the earlier sample with the current one and form the address
  always_comb begin
    prev_ok = IW'(hist_rd_r) < IW'(N_STATES);
    row     = s1_read_r ? s1_from_r : SW'(hist_rd_r);
    col     = s1_read_r ? s1_to_r : s1_cur_r;
    q_idx   = AW'(AW'(row) * AW'(N_STATES) + AW'(col));
    q_cmd.bad = s1_bad_r;
    if (s1_bad_r) begin
      q_cmd.op = ltc_pkg::OP_NONE;
    end else if (s1_read_r) begin
      q_cmd.op = ltc_pkg::OP_READ;
    end else if (s1_elig_r && prev_ok) begin
      q_cmd.op = ltc_pkg::OP_COUNT;
    end else begin
      q_cmd.op = ltc_pkg::OP_NONE;
    end
  end

  assign q_push = s1_valid_r;

endmodule

// File: rtl/ltc_back.sv
// ltc_back: count store with its read-modify-write pipeline, forwarding and the
// clearing pass after reset. Uses ltc_pkg; fed from the command queue.
module ltc_back #(
  parameter int N_STATES   = ltc_pkg::N_STATES_DEF,
  parameter int COUNT_BITS = ltc_pkg::COUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_empty,
  input  ltc_pkg::cmd_t                            q_cmd,
  input  logic [$clog2(N_STATES*N_STATES)-1:0]     q_idx,
  output logic                                     q_pop,
  input  logic [$clog2(ltc_pkg::OUT_DEPTH+1)-1:0]  o_count,
  output logic                                     o_push,
  output ltc_pkg::result_t                         o_data,
  output logic                                     clr_busy
);

  localparam int AW    = $clog2(N_STATES * N_STATES);
  localparam int DEPTH = N_STATES * N_STATES;
  localparam int OCW   = $clog2(ltc_pkg::OUT_DEPTH + 1);
  localparam int OSW   = OCW + 1;

  logic [COUNT_BITS-1:0] store_r [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;

  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  logic          a_valid_r;
  ltc_pkg::cmd_t a_cmd_r;
  logic [AW-1:0] a_idx_r;

  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_idx_r;
  logic [COUNT_BITS-1:0] fwd_val_r;

  logic [COUNT_BITS-1:0] cur_val;
  logic [COUNT_BITS-1:0] inc_val;
  logic                  wr_en;

  assign clr_busy = clr_active_r;
  assign q_pop    = !q_empty && !clr_active_r
                    && ((OSW'(o_count) + OSW'(a_valid_r)) < OSW'(ltc_pkg::OUT_DEPTH));

  always_comb begin
    // Take the value written last cycle when it is the same entry
    cur_val = (fwd_valid_r && (fwd_idx_r == a_idx_r)) ? fwd_val_r : rd_data_r;
    inc_val = (cur_val == '1) ? cur_val : cur_val + COUNT_BITS'(1);
    wr_en   = a_valid_r && (a_cmd_r.op == ltc_pkg::OP_COUNT);
    o_push  = a_valid_r;
    unique case (a_cmd_r.op)
      ltc_pkg::OP_COUNT: begin
        o_data.count_value     = ltc_pkg::OUT_W'(inc_val);
        o_data.pair_counted    = 1'b1;
        o_data.id_out_of_range = 1'b0;
      end
      ltc_pkg::OP_READ: begin
        o_data.count_value     = ltc_pkg::OUT_W'(cur_val);
        o_data.pair_counted    = 1'b0;
        o_data.id_out_of_range = 1'b0;
      end
      default: begin
        o_data.count_value     = '0;
        o_data.pair_counted    = 1'b0;
        o_data.id_out_of_range = a_cmd_r.bad;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      a_valid_r    <= 1'b0;
      fwd_valid_r  <= 1'b0;
    end else begin
      a_valid_r <= q_pop;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cmd_r <= q_cmd;
      a_idx_r <= q_idx;
    end
    if (wr_en) begin
      fwd_idx_r <= a_idx_r;
      fwd_val_r <= inc_val;
    end
  end

  // Count store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      store_r[clr_addr_r] <= '0;
    end else if (wr_en) begin
      store_r[a_idx_r] <= inc_val;
    end
    rd_data_r <= store_r[q_idx];
  end

endmodule

// File: rtl/ltc_checker.sv
// ltc_checker: port-level assertions for lagged_transition_counter, bound to the top.
// Depends on ltc_pkg for port widths.
module ltc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        push,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [ltc_pkg::OUT_W-1:0]   out_count_value,
  input logic                        out_pair_counted,
  input logic                        out_id_out_of_range
);

  logic [7:0] pending_r, pending_nxt;

  // Track transactions taken in but not yet delivered
  always_comb begin
    pending_nxt = pending_r;
    if ((push && !full) && !(pop && !empty)) begin
      pending_nxt = pending_r + 8'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      pending_nxt = pending_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> full)
    else $error("input not held off while the count store is cleared");

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (pending_r != 8'd0))
    else $error("result shown with no transaction outstanding");

  a_flagged_has_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_id_out_of_range) |-> (!out_pair_counted && (out_count_value == '0)))
    else $error("out-of-range result carries a count");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_count_value)))
    else $error("waiting result changed before it was taken");

endmodule

bind lagged_transition_counter ltc_checker u_ltc_checker (.*);
